### rtl/core/pasm_pkg.sv
// ----------------------------------------------------------------------------
// pasm_pkg
// Shared types and constants for the polynomial add/sub/multiply unit.
// ----------------------------------------------------------------------------
package pasm_pkg;

  localparam int COEF_W = 32;  // Q16.16 coefficient
  localparam int FRAC_W = 16;
  localparam int DEG_W  = 5;
  localparam int POW_W  = 6;   // result power port
  localparam int OP_W   = 2;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 2;   // config register index
  localparam int CFG_W  = 5;   // widest config register
  localparam int PROD_W = 2 * COEF_W;
  // 32 full-scale products plus rounding offset need 69 bits signed
  localparam int ACC_W  = 70;

  localparam logic [OP_W-1:0] OP_WR_A    = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_B    = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

  localparam logic [IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_DEG_A = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEG_B = 2'd2;

  localparam logic [ACC_W-1:0] ROUND_INIT = ACC_W'(1) << (FRAC_W - 1);

  // one term issued to the arithmetic unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic mul;
    logic sub;
    logic a_en;
    logic b_en;
  } mac_ctl_t;

  // finished coefficient from the arithmetic unit
  typedef struct packed {
    logic              done;
    logic              sat;
    logic [COEF_W-1:0] value;
  } mac_res_t;

endpackage

### rtl/core/pasm_coef_mem.sv
// ----------------------------------------------------------------------------
// pasm_coef_mem
// Coefficient store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pasm_coef_mem
  import pasm_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [COEF_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [COEF_W-1:0]        rd_data
);

  logic [COEF_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/pasm_mac.sv
// ----------------------------------------------------------------------------
// pasm_mac
// Shared arithmetic unit: multiply or add/sub stage, wide accumulator,
// then round to Q16.16 and saturate to 32 bits.
// ----------------------------------------------------------------------------
module pasm_mac
  import pasm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mac_ctl_t          ctl,
  input  logic [COEF_W-1:0] a_data,
  input  logic [COEF_W-1:0] b_data,
  output mac_res_t          res
);

  localparam int SH_W = ACC_W - FRAC_W;

  mac_ctl_t                  ctl_q1;
  mac_ctl_t                  ctl_q2;
  logic                      fin;
  logic signed [PROD_W-1:0]  term;
  logic signed [PROD_W-1:0]  term_next;
  logic signed [PROD_W-1:0]  prod;
  logic signed [COEF_W:0]    av;
  logic signed [COEF_W:0]    bv;
  logic signed [COEF_W:0]    sum;
  logic [ACC_W-1:0]          acc;
  logic [SH_W-1:0]           shifted;
  logic [SH_W-COEF_W:0]      high_bits;
  logic                      fits;

  assign prod = signed'(a_data) * signed'(b_data);
  assign av   = ctl_q1.a_en ? {a_data[COEF_W-1], a_data} : '0;
  assign bv   = ctl_q1.b_en ? {b_data[COEF_W-1], b_data} : '0;
  assign sum  = ctl_q1.sub ? av - bv : av + bv;

  // add/sub terms are lifted by 16 bits so they share the rounding path
  assign term_next = ctl_q1.mul ? prod
                   : {{(PROD_W - COEF_W - 1 - FRAC_W){sum[COEF_W]}}, sum, {FRAC_W{1'b0}}};

  assign shifted   = acc[ACC_W-1:FRAC_W];
  assign high_bits = shifted[SH_W-1:COEF_W-1];
  assign fits      = (&high_bits) | ~(|high_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q1   <= '0;
      ctl_q2   <= '0;
      fin      <= 1'b0;
      res.done <= 1'b0;
    end else begin
      ctl_q1   <= ctl;
      ctl_q2   <= ctl_q1;
      fin      <= ctl_q2.valid & ctl_q2.last;
      res.done <= fin;
    end
    term <= term_next;
    if (ctl_q2.valid) begin
      acc <= (ctl_q2.first ? ROUND_INIT : acc) + {{(ACC_W - PROD_W){term[PROD_W-1]}}, term};
    end
    if (fin) begin
      res.sat <= ~fits;
      if (fits) begin
        res.value <= shifted[COEF_W-1:0];
      end else if (shifted[SH_W-1]) begin
        res.value <= {1'b1, {(COEF_W - 1){1'b0}}};
      end else begin
        res.value <= {1'b0, {(COEF_W - 1){1'b1}}};
      end
    end
  end

endmodule

### rtl/core/polynomial_add_sub_multiply_unit.sv
// ----------------------------------------------------------------------------
// polynomial_add_sub_multiply_unit
// Dense polynomial A+B, A-B or A*B on signed Q16.16 coefficients.
// ----------------------------------------------------------------------------
// Coefficient write words are accepted whenever the unit is idle. A compute
// word in add, subtract or multiply mode emits one result word per power,
// highest power first, the power-zero word marked last. Each result power
// has a setup step, then its terms, one per cycle, through the shared
// multiplier and accumulator, then pipeline drain, rounding and saturation,
// and an emit step that waits out any output stall. A power sums 1 product
// for add and subtract and up to MAX_TERMS for multiply. The input is not
// ready while a compute word is in progress. Products are summed exactly,
// rounded to nearest with ties up, and clipped to 32 bits with the saturated
// flag set.
// ----------------------------------------------------------------------------
module polynomial_add_sub_multiply_unit
  import pasm_pkg::*;
#(
  parameter int MAX_TERMS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          op,
  input  logic [DEG_W-1:0]         power,
  input  logic signed [COEF_W-1:0] coefficient,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POW_W-1:0]         result_power,
  output logic signed [COEF_W-1:0] result_value,
  output logic                     saturated,
  output logic                     last
);

  localparam int AW = $clog2(MAX_TERMS);
  localparam int PW = $clog2(2 * MAX_TERMS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_ISSUE,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t              state;
  logic [MODE_W-1:0]   mode;
  logic [DEG_W-1:0]    degree_a;
  logic [DEG_W-1:0]    degree_b;
  logic [AW-1:0]       da;
  logic [AW-1:0]       db;
  logic [PW-1:0]       p;
  logic [AW-1:0]       i;
  logic [AW-1:0]       j;
  logic [AW-1:0]       i_lo;
  logic                first;
  logic                accept;
  logic                in_range;
  logic [AW-1:0]       i_hi;
  mac_ctl_t            ctl;
  mac_res_t            res;
  logic [COEF_W-1:0]   a_rd;
  logic [COEF_W-1:0]   b_rd;

  assign da = (int'(degree_a) >= MAX_TERMS) ? AW'(MAX_TERMS - 1) : degree_a[AW-1:0];
  assign db = (int'(degree_b) >= MAX_TERMS) ? AW'(MAX_TERMS - 1) : degree_b[AW-1:0];

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign in_range = int'(power) < MAX_TERMS;
  assign i_hi     = (p > PW'(da)) ? da : p[AW-1:0];

  always_comb begin
    ctl       = '0;
    ctl.valid = (state == S_ISSUE);
    ctl.first = first;
    ctl.last  = (mode != MODE_MUL) || (i == i_lo);
    ctl.mul   = (mode == MODE_MUL);
    ctl.sub   = (mode == MODE_SUB);
    ctl.a_en  = (p <= PW'(da));
    ctl.b_en  = (p <= PW'(db));
  end

  pasm_coef_mem #(.DEPTH(MAX_TERMS)) u_mem_a (
    .clk     (clk),
    .wr_en   (accept && op == OP_WR_A && in_range),
    .wr_addr (power[AW-1:0]),
    .wr_data (coefficient),
    .rd_addr (i),
    .rd_data (a_rd)
  );

  pasm_coef_mem #(.DEPTH(MAX_TERMS)) u_mem_b (
    .clk     (clk),
    .wr_en   (accept && op == OP_WR_B && in_range),
    .wr_addr (power[AW-1:0]),
    .wr_data (coefficient),
    .rd_addr (j),
    .rd_data (b_rd)
  );

  pasm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .a_data (a_rd),
    .b_data (b_rd),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mode      <= MODE_ADD;
      degree_a  <= '0;
      degree_b  <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MODE:  mode     <= cfg_data[MODE_W-1:0];
          REG_DEG_A: degree_a <= cfg_data;
          REG_DEG_B: degree_b <= cfg_data;
          default:   ;
        endcase
      end
      // in S_EMIT the emit arm decides out_valid
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && op == OP_COMPUTE && (mode inside {MODE_ADD, MODE_SUB, MODE_MUL})) begin
            if (mode == MODE_MUL) begin
              p <= PW'(da) + PW'(db);
            end else begin
              p <= (da > db) ? PW'(da) : PW'(db);
            end
            state <= S_START;
          end
        end
        S_START: begin
          first <= 1'b1;
          if (mode == MODE_MUL) begin
            i    <= i_hi;
            j    <= AW'(p - PW'(i_hi));
            i_lo <= (p > PW'(db)) ? AW'(p - PW'(db)) : '0;
          end else begin
            i <= p[AW-1:0];
            j <= p[AW-1:0];
          end
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          first <= 1'b0;
          i     <= i - AW'(1);
          j     <= j + AW'(1);
          if (ctl.last) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (res.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            result_power <= POW_W'(p);
            result_value <= signed'(res.value);
            saturated    <= res.sat;
            last         <= (p == '0);
            if (p == '0) begin
              state <= S_IDLE;
            end else begin
              p     <= p - PW'(1);
              state <= S_START;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### test/tb_polynomial_add_sub_multiply_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polynomial_add_sub_multiply_unit
// Self-checking bench for the polynomial add/sub/multiply unit. A directed
// table covers saturation at both rails, rounding ties, unequal degrees and
// the unused op and mode codes. Random phases follow, each setting mode and
// degrees, loading coefficients in shuffled order and computing. Every result
// word is scored field by field against the directed table or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_polynomial_add_sub_multiply_unit
  import pasm_pkg::*;
();

  localparam int NTERMS   = 32;
  localparam int RES_N    = 2 * NTERMS - 1;
  localparam int SUM_W    = 80;
  localparam int N_WORDS  = 210;
  localparam int SETTLE   = 16;
  localparam logic [OP_W-1:0]   OP_NOP   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_OFF = 2'd3;
  localparam logic signed [SUM_W-1:0] Q_MAX = 80'sh7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] Q_MIN = -80'sh8000_0000;

  typedef struct packed {
    logic              is_reg;
    logic [IDX_W-1:0]  idx;
    logic [CFG_W-1:0]  data;
    logic [OP_W-1:0]   op;
    logic [DEG_W-1:0]  pw;
    logic [COEF_W-1:0] coef;
    logic              typed;
    logic [COEF_W-1:0] t_value;
    logic              t_sat;
  } dir_row_t;

  typedef struct packed {
    logic [POW_W-1:0]  pw;
    logic [COEF_W-1:0] value;
    logic              sat;
    logic              last;
  } coef_word_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [DEG_W-1:0] pw;
  } coef_write_t;

  localparam int DIR_N = 35;
  localparam dir_row_t DIR_TAB [0:DIR_N-1] = '{
    '{1'b0, REG_MODE, 5'd0, OP_WR_A, 5'd0, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_WR_B, 5'd0, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
    // add clips at the top rail
    '{1'b0, REG_MODE, 5'd0, OP_COMPUTE, 5'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{1'b1, REG_MODE, CFG_W'(MODE_SUB), OP_WR_A, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_WR_B, 5'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_COMPUTE, 5'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{1'b0, REG_MODE, 5'd0, OP_WR_A, 5'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_WR_B, 5'd0, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
    // subtract clips at the bottom rail
    '{1'b0, REG_MODE, 5'd0, OP_COMPUTE, 5'd0, 32'h0, 1'b1, 32'h8000_0000, 1'b1},
    '{1'b1, REG_MODE, CFG_W'(MODE_ADD), OP_WR_A, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_COMPUTE, 5'd0, 32'h0, 1'b1, 32'h8000_0001, 1'b0},
    '{1'b1, REG_MODE, CFG_W'(MODE_MUL), OP_WR_A, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    // half an LSB rounds up, for both signs
    '{1'b0, REG_MODE, 5'd0, OP_WR_A, 5'd0, 32'h0000_8000, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_COMPUTE, 5'd0, 32'h0, 1'b1, 32'h0000_0001, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_WR_A, 5'd0, 32'hFFFF_8000, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_COMPUTE, 5'd0, 32'h0, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_WR_A, 5'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_WR_B, 5'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_COMPUTE, 5'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{1'b0, REG_MODE, 5'd0, OP_WR_B, 5'd0, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_COMPUTE, 5'd0, 32'h0, 1'b1, 32'h8000_0000, 1'b1},
    // unequal degrees from here on
    '{1'b1, REG_DEG_A, 5'd1, OP_WR_A, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_WR_A, 5'd1, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_COMPUTE, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_MODE, CFG_W'(MODE_ADD), OP_WR_A, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_COMPUTE, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_DEG_B, 5'd2, OP_WR_A, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_WR_B, 5'd1, 32'hFFFF_0000, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_WR_B, 5'd2, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_MODE, CFG_W'(MODE_SUB), OP_WR_A, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_COMPUTE, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    // unused op, then unused mode: no words out
    '{1'b0, REG_MODE, 5'd0, OP_NOP, 5'd31, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_MODE, CFG_W'(MODE_OFF), OP_WR_A, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_COMPUTE, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b0, REG_MODE, 5'd0, OP_WR_A, 5'd31, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0}
  };

  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     cfg_write   = 1'b0;
  logic [IDX_W-1:0]         cfg_index   = '0;
  logic [CFG_W-1:0]         cfg_data    = '0;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          op          = '0;
  logic [DEG_W-1:0]         power       = '0;
  logic signed [COEF_W-1:0] coefficient = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic [POW_W-1:0]         result_power;
  logic signed [COEF_W-1:0] result_value;
  logic                     saturated;
  logic                     last;

  // predictor state
  logic signed [COEF_W-1:0] coef_a [NTERMS];
  logic signed [COEF_W-1:0] coef_b [NTERMS];
  bit                       a_written [NTERMS];
  bit                       b_written [NTERMS];
  logic [MODE_W-1:0]        cur_mode  = MODE_ADD;
  logic [DEG_W-1:0]         cur_deg_a = '0;
  logic [DEG_W-1:0]         cur_deg_b = '0;

  coef_word_t coefs_due[$];
  int         fails      = 0;
  int         words_sent = 0;
  bit         quiet      = 1'b0;
  int         stall_left = 0;

  polynomial_add_sub_multiply_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .power        (power),
    .coefficient  (coefficient),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_power (result_power),
    .result_value (result_value),
    .saturated    (saturated),
    .last         (last)
  );

  always #4 clk = ~clk;

  function automatic coef_word_t clip_coef(input logic signed [SUM_W-1:0] v, input int p);
    coef_word_t w;
    w.pw   = POW_W'(p);
    w.last = (p == 0);
    w.sat  = 1'b1;
    if (v > Q_MAX) begin
      w.value = Q_MAX[COEF_W-1:0];
    end else if (v < Q_MIN) begin
      w.value = Q_MIN[COEF_W-1:0];
    end else begin
      w.value = v[COEF_W-1:0];
      w.sat   = 1'b0;
    end
    return w;
  endfunction

  // coefficients of A op B, queued highest power first
  task automatic predict_coefs();
    coef_word_t               words [RES_N];
    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  av;
    logic signed [SUM_W-1:0]  bv;
    logic signed [2*COEF_W-1:0] prod;
    int                       top;
    if (cur_mode == MODE_OFF) return;
    if (cur_mode == MODE_MUL) begin
      top = cur_deg_a + cur_deg_b;
      for (int p = 0; p <= top; p++) begin
        acc = '0;
        for (int i = 0; i <= cur_deg_a; i++) begin
          if (p - i >= 0 && p - i <= cur_deg_b) begin
            prod = coef_a[i] * coef_b[p - i];
            acc += prod;
          end
        end
        // exact Q32.32 sum, round half up to Q16.16
        words[p] = clip_coef((acc + 80'sd32768) >>> FRAC_W, p);
      end
    end else begin
      top = (cur_deg_a > cur_deg_b) ? cur_deg_a : cur_deg_b;
      for (int p = 0; p <= top; p++) begin
        av = '0;
        bv = '0;
        if (p <= cur_deg_a) av = coef_a[p];
        if (p <= cur_deg_b) bv = coef_b[p];
        if (cur_mode == MODE_ADD) acc = av + bv;
        else acc = av - bv;
        words[p] = clip_coef(acc, p);
      end
    end
    for (int p = top; p >= 0; p--) coefs_due.push_back(words[p]);
  endtask

  task automatic send_word(input logic [OP_W-1:0] o, input logic [DEG_W-1:0] p,
                           input logic [COEF_W-1:0] c, input bit typed = 1'b0,
                           input logic [COEF_W-1:0] t_value = '0,
                           input logic t_sat = 1'b0);
    coef_word_t w;
    in_valid    <= 1'b1;
    op          <= o;
    power       <= p;
    coefficient <= c;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    case (o)
      OP_WR_A: begin
        coef_a[p]    = c;
        a_written[p] = 1'b1;
      end
      OP_WR_B: begin
        coef_b[p]    = c;
        b_written[p] = 1'b1;
      end
      OP_COMPUTE: begin
        if (typed) begin
          w = '{pw: '0, value: t_value, sat: t_sat, last: 1'b1};
          coefs_due.push_back(w);
        end else begin
          predict_coefs();
        end
      end
      default: ;
    endcase
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (coefs_due.size() != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain_results();
    // a write word may still be in flight with nothing to wait for
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MODE:  cur_mode  = val[MODE_W-1:0];
      REG_DEG_A: cur_deg_a = val[DEG_W-1:0];
      REG_DEG_B: cur_deg_b = val[DEG_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return 32'($signed(17'($urandom)));
      4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // result side: random bursts with out_ready held low
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!rst && !quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    coef_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (coefs_due.size() == 0) begin
        $error("result word with none due, result_power %0d", result_power);
        fails++;
      end else begin
        want = coefs_due.pop_front();
        if (result_power !== want.pw) begin
          $error("result_power: expected %0d, got %0d", want.pw, result_power);
          fails++;
        end
        if (result_value !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, result_value);
          fails++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %b, got %b", want.sat, saturated);
          fails++;
        end
        if (last !== want.last) begin
          $error("last: expected %b, got %b", want.last, last);
          fails++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL polynomial_add_sub_multiply_unit");
    $finish;
  end

  initial begin
    coef_write_t plan[$];
    coef_write_t tmp;
    logic [MODE_W-1:0] m;
    logic [DEG_W-1:0]  da;
    logic [DEG_W-1:0]  db;
    int phase;
    int n_comp;
    int j;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_TAB[r].is_reg) begin
        write_reg(DIR_TAB[r].idx, DIR_TAB[r].data);
      end else begin
        send_word(DIR_TAB[r].op, DIR_TAB[r].pw, DIR_TAB[r].coef, DIR_TAB[r].typed,
                  DIR_TAB[r].t_value, DIR_TAB[r].t_sat);
        sender_gap();
      end
    end

    phase = 0;
    while (words_sent < N_WORDS) begin
      case (phase)
        0: begin m = MODE_MUL; da = 5'd31; db = 5'd31; end
        1: begin m = MODE_ADD; da = 5'd31; db = 5'd0;  end
        2: begin m = MODE_SUB; da = 5'd0;  db = 5'd31; end
        default: begin
          m  = ($urandom_range(0, 9) == 0) ? MODE_OFF : MODE_W'($urandom_range(0, 2));
          da = ($urandom_range(0, 7) == 0) ? 5'd31 : DEG_W'($urandom_range(0, 6));
          db = ($urandom_range(0, 7) == 0) ? 5'd31 : DEG_W'($urandom_range(0, 6));
        end
      endcase
      write_reg(REG_MODE, CFG_W'(m));
      write_reg(REG_DEG_A, CFG_W'(da));
      write_reg(REG_DEG_B, CFG_W'(db));

      n_comp = $urandom_range(1, 3);
      for (int k = 0; k < n_comp; k++) begin
        // load every coefficient in range that is still unset, plus a few others
        plan.delete();
        for (int p = 0; p < NTERMS; p++) begin
          if ((p <= da && !a_written[p]) || $urandom_range(0, 7) == 0)
            plan.push_back('{op: OP_WR_A, pw: DEG_W'(p)});
          if ((p <= db && !b_written[p]) || $urandom_range(0, 7) == 0)
            plan.push_back('{op: OP_WR_B, pw: DEG_W'(p)});
        end
        if ($urandom_range(0, 5) == 0)
          plan.push_back('{op: OP_NOP, pw: DEG_W'($urandom)});
        for (int i = plan.size() - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = plan[i];
          plan[i] = plan[j];
          plan[j] = tmp;
        end
        foreach (plan[i]) begin
          send_word(plan[i].op, plan[i].pw, pick_coef());
          sender_gap();
        end
        send_word(OP_COMPUTE, DEG_W'($urandom), $urandom);
        sender_gap();
        if ($urandom_range(0, 4) == 0) drain_results();
        if (words_sent >= N_WORDS - 40) quiet = 1'b1;
      end
      phase++;
    end

    drain_results();
    repeat (64) @(posedge clk);
    if (fails == 0) begin
      $display("PASS polynomial_add_sub_multiply_unit");
    end else begin
      $display("FAIL polynomial_add_sub_multiply_unit");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/pasm_pkg.sv
rtl/core/pasm_coef_mem.sv
rtl/core/pasm_mac.sv
rtl/core/polynomial_add_sub_multiply_unit.sv
test/tb_polynomial_add_sub_multiply_unit.sv
